// ===== src/rmte_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rotation matrix to Euler angles: shared types and constants
// Transaction structs, pipeline stage struct, CORDIC angle table.
// ---------------------------------------------------------------------------
package rmte_pkg;

   localparam int CORDIC_STEPS = 20;
   localparam int SQRT_STEPS   = 29;
   localparam int VEC_W        = 34;
   localparam int ANG_W        = 24;
   localparam int RAD_W        = 58;

   localparam logic signed [ANG_W-1:0] PI_Q20      = 24'sd3294199;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 24'sd1647099;
   localparam logic signed [16:0]      PI_Q13      = 17'sd25736;
   localparam logic signed [16:0]      HALF_PI_Q13 = 17'sd12868;
   localparam logic signed [15:0]      ONE_Q14     = 16'sd16384;
   localparam logic [14:0]             THRESH_RESET = 15'd16351;

   typedef enum logic [1:0] {
      POLE_REGULAR = 2'd0,
      POLE_NORTH   = 2'd1,
      POLE_SOUTH   = 2'd2
   } pole_type;

   typedef struct packed {
      logic signed [15:0] elem_0;
      logic signed [15:0] elem_2;
      logic signed [15:0] elem_4;
      logic signed [15:0] elem_5;
      logic signed [15:0] elem_6;
      logic signed [15:0] elem_8;
      logic signed [15:0] elem_10;
   } req_type;

   typedef struct packed {
      logic signed [14:0] angle_x;
      logic signed [15:0] angle_y;
      logic signed [15:0] angle_z;
      logic [1:0]         pole_case;
   } rsp_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } vec_type;

   typedef struct packed {
      pole_type           pc;
      logic signed [15:0] s;
      vec_type            vec_x;
      vec_type            vec_y;
      vec_type            vec_z;
      logic [RAD_W-1:0]   n;
      logic [RAD_W-1:0]   r;
   } stage_type;

   function automatic logic signed [ANG_W-1:0] atan_q20(input int i);
      logic signed [ANG_W-1:0] v;
      unique case (i)
         0:       v = 24'sd823550;
         1:       v = 24'sd486170;
         2:       v = 24'sd256879;
         3:       v = 24'sd130396;
         4:       v = 24'sd65451;
         5:       v = 24'sd32757;
         6:       v = 24'sd16383;
         7:       v = 24'sd8192;
         8:       v = 24'sd4096;
         9:       v = 24'sd2048;
         10:      v = 24'sd1024;
         11:      v = 24'sd512;
         12:      v = 24'sd256;
         13:      v = 24'sd128;
         14:      v = 24'sd64;
         15:      v = 24'sd32;
         16:      v = 24'sd16;
         17:      v = 24'sd8;
         18:      v = 24'sd4;
         default: v = 24'sd2;
      endcase
      return v;
   endfunction

endpackage

// ===== src/rotation_matrix_to_euler.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rotation matrix to Euler angles
// Gimbal pole detection, asin via square root and CORDIC, two atan2 paths.
// ---------------------------------------------------------------------------
// The block takes one matrix transaction every cycle while req_stall is low
// and passes it through one input register, a row of 29 square root cells
// for the asin cosine term, a row of 20 CORDIC cells that rotate all three
// vectors side by side, and the output register. Every cell holds its own
// valid bit, so a stalled output only stops the cells that are full; gaps in
// the row close up while the output waits. The pole threshold register is
// sampled when a transaction enters.
module rotation_matrix_to_euler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmte_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmte_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [14:0]       csr_write_data
);
   import rmte_pkg::*;

   logic [14:0] thresh_ff;

   logic      sq_valid [0:SQRT_STEPS];
   logic      sq_ready [0:SQRT_STEPS];
   stage_type sq_data  [0:SQRT_STEPS];

   logic      cd_valid [0:CORDIC_STEPS];
   logic      cd_ready [0:CORDIC_STEPS];
   stage_type cd_data  [0:CORDIC_STEPS];

   logic      valid0_ff;
   stage_type data0_ff;
   stage_type data0_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      ready0;
   logic      rsp_ready;

   function automatic logic signed [VEC_W-1:0] to_q28(input logic signed [16:0] v);
      return {{(VEC_W-31){v[16]}}, v, 14'b0};
   endfunction

   function automatic vec_type prerotate(input logic signed [16:0] y,
                                         input logic signed [16:0] x);
      vec_type                 o;
      logic signed [VEC_W-1:0] qx;
      logic signed [VEC_W-1:0] qy;
      qx     = to_q28(x);
      qy     = to_q28(y);
      o.zero = (x == 17'sd0) && (y == 17'sd0);
      o.x    = qx;
      o.y    = qy;
      o.z    = '0;
      if (qx < 0) begin
         if (qy >= 0) begin
            o.x = qy;
            o.y = -qx;
            o.z = HALF_PI_Q20;
         end else begin
            o.x = -qy;
            o.y = qx;
            o.z = -HALF_PI_Q20;
         end
      end
      return o;
   endfunction

   function automatic logic signed [16:0] to_q13(input vec_type v);
      logic signed [ANG_W-1:0] z;
      logic signed [ANG_W-1:0] t;
      logic signed [16:0]      r;
      z = v.z;
      if (z > PI_Q20) begin
         z = PI_Q20;
      end
      if (z < -PI_Q20) begin
         z = -PI_Q20;
      end
      if (z >= 0) begin
         t = (z + 24'sd64) >>> 7;
      end else begin
         t = -((-z + 24'sd64) >>> 7);
      end
      r = t[16:0];
      if (r > PI_Q13) begin
         r = PI_Q13;
      end
      if (r < -PI_Q13) begin
         r = -PI_Q13;
      end
      if (v.zero) begin
         r = '0;
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_write_enable) begin
         thresh_ff <= csr_write_data;
      end
   end

   always_comb begin
      logic signed [16:0] e4;
      logic signed [16:0] th;
      logic signed [15:0] s;
      logic [31:0]        sq;
      logic [28:0]        c2;
      logic               pole;
      e4 = {req_data.elem_4[15], req_data.elem_4};
      th = $signed({2'b0, thresh_ff});
      s  = req_data.elem_4;
      if (req_data.elem_4 > ONE_Q14) begin
         s = ONE_Q14;
      end
      if (req_data.elem_4 < -ONE_Q14) begin
         s = -ONE_Q14;
      end
      priority if (e4 > th) begin
         data0_in.pc = POLE_NORTH;
      end else if (e4 < -th) begin
         data0_in.pc = POLE_SOUTH;
      end else begin
         data0_in.pc = POLE_REGULAR;
      end
      pole = (data0_in.pc != POLE_REGULAR);
      sq   = 32'(s * s);
      c2   = 29'(29'h1000_0000 - sq[28:0]);
      data0_in.s     = s;
      data0_in.n     = {1'b0, c2, 28'b0};
      data0_in.r     = '0;
      data0_in.vec_x = '0;
      if (pole) begin
         data0_in.vec_y = prerotate({req_data.elem_2[15], req_data.elem_2},
                                    {req_data.elem_10[15], req_data.elem_10});
      end else begin
         data0_in.vec_y = prerotate(-{req_data.elem_8[15], req_data.elem_8},
                                    {req_data.elem_0[15], req_data.elem_0});
      end
      data0_in.vec_z = prerotate(-{req_data.elem_6[15], req_data.elem_6},
                                 {req_data.elem_5[15], req_data.elem_5});
   end

   assign ready0    = !valid0_ff || sq_ready[0];
   assign req_stall = !ready0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (ready0) begin
         valid0_ff <= req_valid;
      end
      if (ready0 && req_valid) begin
         data0_ff <= data0_in;
      end
   end

   assign sq_valid[0] = valid0_ff;
   assign sq_data[0]  = data0_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      rmte_sqrt_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_ready  (sq_ready[k]),
         .in_data   (sq_data[k]),
         .out_valid (sq_valid[k+1]),
         .out_ready (sq_ready[k+1]),
         .out_data  (sq_data[k+1])
      );
   end

   always_comb begin
      cd_data[0]            = sq_data[SQRT_STEPS];
      cd_data[0].vec_x.x    = $signed({{(VEC_W-SQRT_STEPS){1'b0}},
                                       sq_data[SQRT_STEPS].r[SQRT_STEPS-1:0]});
      cd_data[0].vec_x.y    = {{(VEC_W-30){sq_data[SQRT_STEPS].s[15]}},
                               sq_data[SQRT_STEPS].s, 14'b0};
      cd_data[0].vec_x.z    = '0;
      cd_data[0].vec_x.zero = 1'b0;
   end

   assign cd_valid[0]          = sq_valid[SQRT_STEPS];
   assign sq_ready[SQRT_STEPS] = cd_ready[0];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      rmte_cordic_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cd_valid[k]),
         .in_ready  (cd_ready[k]),
         .in_data   (cd_data[k]),
         .out_valid (cd_valid[k+1]),
         .out_ready (cd_ready[k+1]),
         .out_data  (cd_data[k+1])
      );
   end

   assign rsp_ready              = !rsp_valid_ff || !rsp_stall;
   assign cd_ready[CORDIC_STEPS] = rsp_ready;

   always_comb begin
      logic signed [16:0] ax;
      stage_type          d;
      d  = cd_data[CORDIC_STEPS];
      ax = to_q13(d.vec_x);
      if (ax > HALF_PI_Q13) begin
         ax = HALF_PI_Q13;
      end
      if (ax < -HALF_PI_Q13) begin
         ax = -HALF_PI_Q13;
      end
      rsp_data_in.pole_case = d.pc;
      rsp_data_in.angle_y   = 16'(to_q13(d.vec_y));
      unique case (d.pc)
         POLE_NORTH: begin
            rsp_data_in.angle_x = HALF_PI_Q13[14:0];
            rsp_data_in.angle_z = '0;
         end
         POLE_SOUTH: begin
            rsp_data_in.angle_x = 15'(-HALF_PI_Q13);
            rsp_data_in.angle_z = '0;
         end
         default: begin
            rsp_data_in.angle_x = ax[14:0];
            rsp_data_in.angle_z = 16'(to_q13(d.vec_z));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= cd_valid[CORDIC_STEPS];
      end
      if (rsp_ready && cd_valid[CORDIC_STEPS]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pole_z_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.pole_case != POLE_REGULAR) |-> rsp_data.angle_z == 16'sd0)
      else $error("angle_z not zero at a pole");

   a_north_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.pole_case == POLE_NORTH) |-> rsp_data.angle_x == 15'sd12868)
      else $error("angle_x wrong at north pole");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

endmodule

// ===== src/rmte_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Square root cell
// One result bit of the integer square root per cell, registered.
// ---------------------------------------------------------------------------
module rmte_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rmte_pkg::stage_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rmte_pkg::stage_type out_data
);
   import rmte_pkg::*;

   localparam int SHIFT = 2 * (SQRT_STEPS - 1 - STEP);
   localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << SHIFT;

   logic             valid_ff;
   stage_type        data_ff;
   stage_type        data_in;
   logic [RAD_W-1:0] trial;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in = in_data;
      trial   = in_data.r + BIT;
      if (in_data.n >= trial) begin
         data_in.n = in_data.n - trial;
         data_in.r = (in_data.r >> 1) + BIT;
      end else begin
         data_in.r = in_data.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/rmte_cordic_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation on each of the three angle vectors, registered.
// ---------------------------------------------------------------------------
module rmte_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rmte_pkg::stage_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output rmte_pkg::stage_type out_data
);
   import rmte_pkg::*;

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   function automatic vec_type rotate(input vec_type v);
      vec_type                 o;
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      o  = v;
      dx = v.y >>> STEP;
      dy = v.x >>> STEP;
      if (!v.y[VEC_W-1]) begin
         o.x = v.x + dx;
         o.y = v.y - dy;
         o.z = v.z + atan_q20(STEP);
      end else begin
         o.x = v.x - dx;
         o.y = v.y + dy;
         o.z = v.z - atan_q20(STEP);
      end
      return o;
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in       = in_data;
      data_in.vec_x = rotate(in_data.vec_x);
      data_in.vec_y = rotate(in_data.vec_y);
      data_in.vec_z = rotate(in_data.vec_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
